FILE: rtl/core/rv_pkg.sv
// ----------------------------------------------------------------------------
// rv_pkg
// Shared widths, codes and types of the radial vignette pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package rv_pkg;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 11;
  localparam int CH_W       = 16;
  localparam int STR_W      = 16;
  localparam int SQ_W       = 23;   // squared distance, row^2 + col^2
  localparam int Q_W        = 30;   // quotient of sd * 2^30 / sc
  localparam int RT_W       = Q_W / 2;
  localparam int REM_W      = RT_W + 2;
  localparam int RATIO_W    = 16;
  localparam int DIV_STEPS  = Q_W;
  localparam int SQRT_STEPS = RT_W;

  localparam logic [RATIO_W-1:0] ONE_Q15 = 16'h8000;

  typedef enum logic [1:0] {
    CFG_CENTER_ROW = 2'd0,
    CFG_CENTER_COL = 2'd1,
    CFG_STRENGTH   = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // ratio override decided ahead of the divider
  typedef struct packed {
    logic full;
    logic zero;
  } rsel_t;
endpackage
`default_nettype wire

FILE: rtl/core/rv_front.sv
// ----------------------------------------------------------------------------
// rv_front
// Offsets, squares and squared distances; picks the ratio overrides.
// ----------------------------------------------------------------------------
`default_nettype none
module rv_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [rv_pkg::ROW_W-1:0] row,
  input  wire logic [rv_pkg::COL_W-1:0] col,
  input  wire rv_pkg::pix_t             pix,
  input  wire logic [rv_pkg::ROW_W-1:0] center_row,
  input  wire logic [rv_pkg::COL_W-1:0] center_col,
  output logic                          out_valid,
  output logic [rv_pkg::SQ_W-1:0]       sd,
  output logic [rv_pkg::SQ_W-1:0]       sc,
  output rv_pkg::rsel_t                 sel,
  output rv_pkg::pix_t                  pix_o
);
  logic                       v1, v2;
  logic [rv_pkg::ROW_W-1:0]   dr;
  logic [rv_pkg::COL_W-1:0]   dc;
  logic [2*rv_pkg::ROW_W-1:0] dr2, cr2;
  logic [2*rv_pkg::COL_W-1:0] dc2, cc2;
  rv_pkg::pix_t               pix1, pix2;
  logic [rv_pkg::SQ_W-1:0]    sd_next, sc_next;

  assign sd_next = rv_pkg::SQ_W'(dr2) + rv_pkg::SQ_W'(dc2);
  assign sc_next = rv_pkg::SQ_W'(cr2) + rv_pkg::SQ_W'(cc2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr   <= (row >= center_row) ? row - center_row : center_row - row;
      dc   <= (col >= center_col) ? col - center_col : center_col - col;
      pix1 <= pix;
      dr2  <= dr * dr;
      dc2  <= dc * dc;
      cr2  <= center_row * center_row;
      cc2  <= center_col * center_col;
      pix2 <= pix1;
      sd   <= sd_next;
      sc   <= sc_next;
      sel.zero <= (sd_next == '0);
      sel.full <= (sc_next == '0) ? (sd_next != '0) : (sd_next >= sc_next);
      pix_o <= pix2;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/rv_divider.sv
// ----------------------------------------------------------------------------
// rv_divider
// Restoring divider, one quotient bit per stage: floor(sd * 2^30 / sc).
// ----------------------------------------------------------------------------
`default_nettype none
module rv_divider (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [rv_pkg::SQ_W-1:0] sd,
  input  wire logic [rv_pkg::SQ_W-1:0] sc,
  input  wire rv_pkg::rsel_t          sel,
  input  wire rv_pkg::pix_t           pix,
  output logic                        out_valid,
  output logic [rv_pkg::Q_W-1:0]      quo,
  output rv_pkg::rsel_t               sel_o,
  output rv_pkg::pix_t                pix_o
);
  localparam int N = rv_pkg::DIV_STEPS;

  logic                    v   [0:N];
  logic [rv_pkg::SQ_W-1:0] rm  [0:N];
  logic [rv_pkg::SQ_W-1:0] dv  [0:N];
  logic [rv_pkg::Q_W-1:0]  q   [0:N];
  rv_pkg::rsel_t           sl  [0:N];
  rv_pkg::pix_t            px  [0:N];

  assign v[0]  = in_valid;
  assign rm[0] = sd;
  assign dv[0] = sc;
  assign q[0]  = '0;
  assign sl[0] = sel;
  assign px[0] = pix;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [rv_pkg::SQ_W:0] r2;
    logic                  ge;
    assign r2 = {rm[i], 1'b0};
    assign ge = (r2 >= {1'b0, dv[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[i+1] <= ge ? rv_pkg::SQ_W'(r2 - {1'b0, dv[i]}) : rv_pkg::SQ_W'(r2);
        dv[i+1] <= dv[i];
        q[i+1]  <= {q[i][rv_pkg::Q_W-2:0], ge};
        sl[i+1] <= sl[i];
        px[i+1] <= px[i];
      end
    end
  end

  assign out_valid = v[N];
  assign quo       = q[N];
  assign sel_o     = sl[N];
  assign pix_o     = px[N];
endmodule
`default_nettype wire

FILE: rtl/core/rv_sqrt.sv
// ----------------------------------------------------------------------------
// rv_sqrt
// Digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module rv_sqrt (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [rv_pkg::Q_W-1:0] quo,
  input  wire rv_pkg::rsel_t         sel,
  input  wire rv_pkg::pix_t          pix,
  output logic                       out_valid,
  output logic [rv_pkg::RT_W-1:0]    root,
  output rv_pkg::rsel_t              sel_o,
  output rv_pkg::pix_t               pix_o
);
  localparam int N = rv_pkg::SQRT_STEPS;

  logic                     v  [0:N];
  logic [rv_pkg::REM_W-1:0] rm [0:N];
  logic [rv_pkg::RT_W-1:0]  rt [0:N];
  logic [rv_pkg::Q_W-1:0]   qs [0:N];
  rv_pkg::rsel_t            sl [0:N];
  rv_pkg::pix_t             px [0:N];

  assign v[0]  = in_valid;
  assign rm[0] = '0;
  assign rt[0] = '0;
  assign qs[0] = quo;
  assign sl[0] = sel;
  assign px[0] = pix;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [rv_pkg::REM_W+1:0] cur;
    logic [rv_pkg::REM_W+1:0] trial;
    logic                     ge;
    assign cur   = {rm[i], qs[i][rv_pkg::Q_W-1 -: 2]};
    assign trial = {2'b00, rt[i], 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[i+1] <= ge ? rv_pkg::REM_W'(cur - trial) : rv_pkg::REM_W'(cur);
        rt[i+1] <= {rt[i][rv_pkg::RT_W-2:0], ge};
        qs[i+1] <= {qs[i][rv_pkg::Q_W-3:0], 2'b00};
        sl[i+1] <= sl[i];
        px[i+1] <= px[i];
      end
    end
  end

  assign out_valid = v[N];
  assign root      = rt[N];
  assign sel_o     = sl[N];
  assign pix_o     = px[N];
endmodule
`default_nettype wire

FILE: rtl/core/rv_scale.sv
// ----------------------------------------------------------------------------
// rv_scale
// Ratio select, darkening factor and per-channel scaling over four stages.
// ----------------------------------------------------------------------------
`default_nettype none
module rv_scale (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [rv_pkg::RT_W-1:0] root,
  input  wire rv_pkg::rsel_t           sel,
  input  wire rv_pkg::pix_t            pix,
  input  wire logic [rv_pkg::STR_W-1:0] strength,
  output logic                         out_valid,
  output rv_pkg::pix_t                 pix_o
);
  logic                         va, vb, vc;
  logic [rv_pkg::RATIO_W-1:0]   ratio, str_sat, factor;
  logic [2*rv_pkg::RATIO_W-1:0] prod;
  logic [rv_pkg::CH_W+rv_pkg::RATIO_W-1:0] pr, pg, pb;
  rv_pkg::pix_t                 pxa, pxb, pxc;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (sel.zero)  ratio <= '0;
      else if (sel.full)      ratio <= rv_pkg::ONE_Q15;
      else                    ratio <= rv_pkg::RATIO_W'(root);
      str_sat <= (strength > rv_pkg::ONE_Q15) ? rv_pkg::ONE_Q15 : strength;
      pxa     <= pix;
      prod    <= ratio * str_sat;
      pxb     <= pxa;
      factor  <= rv_pkg::ONE_Q15 - prod[30:15];
      pxc     <= pxb;
      pr      <= pxc.red   * factor;
      pg      <= pxc.green * factor;
      pb      <= pxc.blue  * factor;
    end
  end

  assign pix_o.red   = pr[30:15];
  assign pix_o.green = pg[30:15];
  assign pix_o.blue  = pb[30:15];
endmodule
`default_nettype wire

FILE: rtl/core/radial_vignette_core.sv
// ----------------------------------------------------------------------------
// radial_vignette_core
// Radial vignette: darkens each pixel by its distance from a set centre.
// ----------------------------------------------------------------------------
// Input words on s_*: pixel row, column and three Q4.12 channels. Output
// words on m_*: the three channels scaled by 1 - strength * ratio.
// The cfg port writes the centre row, centre column and strength; write it
// only while no word is in flight. Index 3 is ignored.
// One word is taken per clock while s_tready is high. From acceptance to
// m_tvalid a word passes 3 front stages, 30 divider stages (one quotient
// bit each), 15 square-root stages (one root bit each), 4 scaling stages
// and the output register. The divider sets the depth.
// A two-entry output stage (register plus skid) holds results while the
// receiver stalls; the pipeline freezes only once the skid entry is full,
// and s_tready drops with it. Nothing is lost or repeated.
// Reset empties the pipeline and restores centre 512/1024, strength 0.5.
// ----------------------------------------------------------------------------
`default_nettype none
module radial_vignette_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // pixel_row[9:0], pixel_col[20:10], red_in[36:21], green_in[52:37],
  // blue_in[68:53], zero fill[71:69]
  input  wire logic [71:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // red_out[15:0], green_out[31:16], blue_out[47:32]
  output logic [47:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  logic [rv_pkg::ROW_W-1:0] center_row;
  logic [rv_pkg::COL_W-1:0] center_col;
  logic [rv_pkg::STR_W-1:0] strength;
  logic                     en;
  rv_pkg::pix_t             pix_in;

  logic                    f_valid, d_valid, q_valid, t_valid;
  logic [rv_pkg::SQ_W-1:0] f_sd, f_sc;
  rv_pkg::rsel_t           f_sel, d_sel, q_sel;
  rv_pkg::pix_t            f_pix, d_pix, q_pix, t_pix;
  logic [rv_pkg::Q_W-1:0]  d_quo;
  logic [rv_pkg::RT_W-1:0] q_root;

  logic         skid_valid, push;
  rv_pkg::pix_t skid, out_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_row <= 10'd512;
      center_col <= 11'd1024;
      strength   <= 16'd16384;
    end else if (cfg_we) begin
      unique case (rv_pkg::cfg_idx_t'(cfg_index))
        rv_pkg::CFG_CENTER_ROW: center_row <= cfg_data[rv_pkg::ROW_W-1:0];
        rv_pkg::CFG_CENTER_COL: center_col <= cfg_data[rv_pkg::COL_W-1:0];
        rv_pkg::CFG_STRENGTH:   strength   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !skid_valid;
  assign s_tready = en;
  assign pix_in.red   = s_tdata[36:21];
  assign pix_in.green = s_tdata[52:37];
  assign pix_in.blue  = s_tdata[68:53];

  rv_front u_front (
    .clk, .rst, .en,
    .in_valid   (s_tvalid && en),
    .row        (s_tdata[9:0]),
    .col        (s_tdata[20:10]),
    .pix        (pix_in),
    .center_row, .center_col,
    .out_valid  (f_valid),
    .sd         (f_sd),
    .sc         (f_sc),
    .sel        (f_sel),
    .pix_o      (f_pix)
  );

  rv_divider u_div (
    .clk, .rst, .en,
    .in_valid  (f_valid),
    .sd        (f_sd),
    .sc        (f_sc),
    .sel       (f_sel),
    .pix       (f_pix),
    .out_valid (d_valid),
    .quo       (d_quo),
    .sel_o     (d_sel),
    .pix_o     (d_pix)
  );

  rv_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid  (d_valid),
    .quo       (d_quo),
    .sel       (d_sel),
    .pix       (d_pix),
    .out_valid (q_valid),
    .root      (q_root),
    .sel_o     (q_sel),
    .pix_o     (q_pix)
  );

  rv_scale u_scale (
    .clk, .rst, .en,
    .in_valid  (q_valid),
    .root      (q_root),
    .sel       (q_sel),
    .pix       (q_pix),
    .strength,
    .out_valid (t_valid),
    .pix_o     (t_pix)
  );

  assign push = en && t_valid;

  // drain the skid entry first; park the tail word there on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      out_pix <= skid_valid ? skid : t_pix;
    end else if (push) begin
      skid <= t_pix;
    end
  end

  assign m_tdata = {out_pix.blue, out_pix.green, out_pix.red};
endmodule
`default_nettype wire
